>>> rtl/sfs_pkg.sv
// Shared types and constants for the smoothstep fade sequencer.
package sfs_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned DT_W    = 20;
  localparam int unsigned FTIME_W = 24;
  localparam int unsigned ALPHA_W = 16;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OP_W-1:0] OP_FADE_IN  = 3'd1;
  localparam logic [OP_W-1:0] OP_FADE_OUT = 3'd2;
  localparam logic [OP_W-1:0] OP_IN_HOLD  = 3'd3;
  localparam logic [OP_W-1:0] OP_SET      = 3'd4;

  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_IN   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_OUT  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_HOLD = 2'd3;

  localparam logic [CIDX_W-1:0] CFG_FADE_IN  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_FADE_OUT = 2'd1;

  localparam logic [FTIME_W-1:0] DEF_FADE = 24'd500000;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [DT_W-1:0]    dt;
    logic [FTIME_W-1:0] in_time;
    logic [FTIME_W-1:0] hold_time;
    logic [FTIME_W-1:0] out_time;
    logic [ALPHA_W-1:0] alpha_set;
  } in_item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [PHASE_W-1:0] phase;
    logic               on_top;
    logic               fade_in_done;
    logic               all_done;
  } out_item_t;

endpackage

>>> rtl/smoothstep_fade_sequencer.sv
// Top level: smoothstep alpha fade sequencer with shared divider and multiplier.
//
//   port group | direction | handshake            | payload
//   in_        | input     | in_valid / in_stall   | sfs_pkg::in_item_t
//   out_       | output    | out_valid / out_stall | sfs_pkg::out_item_t
//   cfg_       | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Commands and ticks that need no divide go from S_EXEC straight to S_DONE.
// A tick inside a running fade that does not finish it runs ALPHA_FRAC_BITS + 1
// divider steps, then three passes through the one
// shared multiplier. One item is in work at a time; in_stall is high until the
// result is loaded into the output register, which waits while it holds a valid item and out_stall is high.
// Reset is synchronous, with no clearing pass. cfg_ready is always high.
module smoothstep_fade_sequencer #(
  parameter int unsigned TIME_BITS       = 24,
  parameter int unsigned ALPHA_FRAC_BITS = 15
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sfs_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sfs_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sfs_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [sfs_pkg::FTIME_W-1:0]        cfg_data
);

  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned F  = ALPHA_FRAC_BITS;
  localparam int unsigned AW = F + 1;
  localparam int unsigned XW = (AW > sfs_pkg::ALPHA_W) ? AW : sfs_pkg::ALPHA_W;
  localparam int unsigned MA = 2 * F + 1;
  localparam int unsigned MB = F + 2;
  localparam int unsigned PW = MA + MB;
  localparam int unsigned HW = (TW > sfs_pkg::DT_W) ? TW : sfs_pkg::DT_W;
  localparam int unsigned SW = HW + 1;

  localparam logic [AW-1:0] ALPHA_ONE   = {1'b1, {F{1'b0}}};
  localparam logic [MB-1:0] THREE_ONE   = {2'b11, {F{1'b0}}};
  localparam logic [PW-1:0] HALF_SMOOTH = PW'(1) << (2 * F - 1);
  localparam logic [PW-1:0] HALF_INTERP = PW'(1) << (F - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DIV, S_MUL1, S_MUL2, S_SMOOTH, S_MUL3, S_APPLY, S_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  sfs_pkg::in_item_t             item_r, item_nxt;
  sfs_pkg::out_item_t            out_data_r, out_data_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [TW-1:0]                 dfi_r, dfi_nxt;
  logic [TW-1:0]                 dfo_r, dfo_nxt;
  logic [sfs_pkg::PHASE_W-1:0]   phase_r, phase_nxt;
  logic [AW-1:0]                 alpha_now_r, alpha_now_nxt;
  logic [AW-1:0]                 alpha_from_r, alpha_from_nxt;
  logic [AW-1:0]                 alpha_to_r, alpha_to_nxt;
  logic [TW-1:0]                 elapsed_r, elapsed_nxt;
  logic [TW-1:0]                 fade_len_r, fade_len_nxt;
  logic [TW-1:0]                 hold_left_r, hold_left_nxt;
  logic [TW-1:0]                 out_ovr_r, out_ovr_nxt;
  logic                          fi_armed_r, fi_armed_nxt;
  logic                          all_armed_r, all_armed_nxt;
  logic                          front_r, front_nxt;
  logic                          in_pulse_r, in_pulse_nxt;
  logic                          all_pulse_r, all_pulse_nxt;
  logic [AW-1:0]                 t_r, t_nxt;
  logic [AW-1:0]                 s_r, s_nxt;
  logic [PW-1:0]                 prod_r, prod_nxt;

  logic [MA-1:0]                 mul_a;
  logic [MB-1:0]                 mul_b;
  logic [PW-1:0]                 mul_p;
  logic                          div_start;
  logic                          div_done;
  logic [AW-1:0]                 div_quo;

  logic [TW-1:0]                 stored_out;
  logic [TW-1:0]                 in_len;
  logic [TW-1:0]                 out_len;
  logic [TW-1:0]                 t_in_time;
  logic [TW-1:0]                 t_hold_time;
  logic [TW-1:0]                 t_out_time;
  logic [SW-1:0]                 elapsed_sum;
  logic [TW-1:0]                 elapsed_sat;
  logic [AW-1:0]                 alpha_diff;
  logic [PW-1:0]                 smooth_sum;
  logic [PW-1:0]                 interp_sum;
  logic [AW-1:0]                 delta;
  logic [AW-1:0]                 set_val;

  sfs_div #(
    .NUM_BITS (TW),
    .Q_BITS   (AW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (elapsed_sat),
    .den   (fade_len_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign mul_p = mul_a * mul_b;

  always_comb begin
    t_in_time   = TW'(item_r.in_time);
    t_hold_time = TW'(item_r.hold_time);
    t_out_time  = TW'(item_r.out_time);
    stored_out  = (out_ovr_r != '0) ? out_ovr_r : dfo_r;
    in_len      = (t_in_time != '0) ? t_in_time : dfi_r;
    out_len     = (t_out_time != '0) ? t_out_time : stored_out;
    elapsed_sum = SW'(elapsed_r) + SW'(item_r.dt);
    elapsed_sat = (elapsed_sum > SW'(fade_len_r)) ? fade_len_r : TW'(elapsed_sum);
    alpha_diff  = (alpha_to_r >= alpha_from_r) ? (alpha_to_r - alpha_from_r)
                                               : (alpha_from_r - alpha_to_r);
    smooth_sum  = prod_r + HALF_SMOOTH;
    interp_sum  = prod_r + HALF_INTERP;
    delta       = interp_sum[2*F:F];
    set_val     = (XW'(item_r.alpha_set) > XW'(ALPHA_ONE)) ? ALPHA_ONE
                                                          : AW'(item_r.alpha_set);
  end

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    dfi_nxt        = dfi_r;
    dfo_nxt        = dfo_r;
    phase_nxt      = phase_r;
    alpha_now_nxt  = alpha_now_r;
    alpha_from_nxt = alpha_from_r;
    alpha_to_nxt   = alpha_to_r;
    elapsed_nxt    = elapsed_r;
    fade_len_nxt   = fade_len_r;
    hold_left_nxt  = hold_left_r;
    out_ovr_nxt    = out_ovr_r;
    fi_armed_nxt   = fi_armed_r;
    all_armed_nxt  = all_armed_r;
    front_nxt      = front_r;
    in_pulse_nxt   = in_pulse_r;
    all_pulse_nxt  = all_pulse_r;
    t_nxt          = t_r;
    s_nxt          = s_r;
    prod_nxt       = prod_r;
    mul_a          = '0;
    mul_b          = '0;
    div_start      = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        sfs_pkg::CFG_FADE_IN:  dfi_nxt = TW'(cfg_data);
        sfs_pkg::CFG_FADE_OUT: dfo_nxt = TW'(cfg_data);
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        in_pulse_nxt  = 1'b0;
        all_pulse_nxt = 1'b0;
        state_nxt     = S_DONE;
        unique case (item_r.op) inside
          sfs_pkg::OP_TICK: begin
            unique case (phase_r)
              sfs_pkg::PH_IDLE: front_nxt = 1'b0;
              sfs_pkg::PH_HOLD: begin
                if (HW'(item_r.dt) >= HW'(hold_left_r)) begin
                  hold_left_nxt  = '0;
                  alpha_from_nxt = ALPHA_ONE;
                  alpha_to_nxt   = '0;
                  fade_len_nxt   = stored_out;
                  elapsed_nxt    = '0;
                  phase_nxt      = sfs_pkg::PH_OUT;
                  alpha_now_nxt  = ALPHA_ONE;
                end else begin
                  hold_left_nxt = hold_left_r - TW'(item_r.dt);
                end
              end
              default: begin
                front_nxt   = 1'b1;
                elapsed_nxt = elapsed_sat;
                if (elapsed_sat == fade_len_r) begin
                  alpha_now_nxt = alpha_to_r;
                  in_pulse_nxt  = (phase_r == sfs_pkg::PH_IN) && fi_armed_r;
                  if (hold_left_r != '0) begin
                    phase_nxt = sfs_pkg::PH_HOLD;
                  end else begin
                    phase_nxt     = sfs_pkg::PH_IDLE;
                    all_pulse_nxt = all_armed_r;
                    fi_armed_nxt  = 1'b0;
                    all_armed_nxt = 1'b0;
                  end
                end else begin
                  div_start = 1'b1;
                  state_nxt = S_DIV;
                end
              end
            endcase
          end
          sfs_pkg::OP_FADE_IN, sfs_pkg::OP_IN_HOLD: begin
            fi_armed_nxt   = 1'b1;
            all_armed_nxt  = (item_r.op == sfs_pkg::OP_IN_HOLD);
            hold_left_nxt  = (item_r.op == sfs_pkg::OP_IN_HOLD) ? t_hold_time : '0;
            if ((item_r.op == sfs_pkg::OP_IN_HOLD) && (t_out_time != '0)) begin
              out_ovr_nxt = t_out_time;
            end
            alpha_from_nxt = alpha_now_r;
            alpha_to_nxt   = ALPHA_ONE;
            fade_len_nxt   = in_len;
            elapsed_nxt    = '0;
            phase_nxt      = (ALPHA_ONE > alpha_now_r) ? sfs_pkg::PH_IN : sfs_pkg::PH_OUT;
          end
          sfs_pkg::OP_FADE_OUT: begin
            fi_armed_nxt   = 1'b0;
            all_armed_nxt  = 1'b1;
            hold_left_nxt  = '0;
            alpha_from_nxt = alpha_now_r;
            alpha_to_nxt   = '0;
            fade_len_nxt   = out_len;
            elapsed_nxt    = '0;
            phase_nxt      = sfs_pkg::PH_OUT;
          end
          sfs_pkg::OP_SET: begin
            alpha_now_nxt = set_val;
            phase_nxt     = sfs_pkg::PH_IDLE;
            elapsed_nxt   = '0;
            fade_len_nxt  = '0;
            hold_left_nxt = '0;
            fi_armed_nxt  = 1'b0;
            all_armed_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          t_nxt     = div_quo;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        mul_a     = MA'(t_r);
        mul_b     = MB'(t_r);
        prod_nxt  = mul_p;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        mul_a     = prod_r[MA-1:0];
        mul_b     = THREE_ONE - {t_r, 1'b0};
        prod_nxt  = mul_p;
        state_nxt = S_SMOOTH;
      end
      S_SMOOTH: begin
        s_nxt     = smooth_sum[3*F:2*F];
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        mul_a     = MA'(alpha_diff);
        mul_b     = MB'(s_r);
        prod_nxt  = mul_p;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        alpha_now_nxt = (alpha_to_r >= alpha_from_r) ? (alpha_from_r + delta)
                                                     : (alpha_from_r - delta);
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.alpha        = sfs_pkg::ALPHA_W'(alpha_now_r);
          out_data_nxt.phase        = phase_r;
          out_data_nxt.on_top       = front_r;
          out_data_nxt.fade_in_done = in_pulse_r;
          out_data_nxt.all_done     = all_pulse_r;
          out_valid_nxt             = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      item_r       <= '0;
      out_data_r   <= '0;
      out_valid_r  <= 1'b0;
      dfi_r        <= TW'(sfs_pkg::DEF_FADE);
      dfo_r        <= TW'(sfs_pkg::DEF_FADE);
      phase_r      <= sfs_pkg::PH_IDLE;
      alpha_now_r  <= '0;
      alpha_from_r <= '0;
      alpha_to_r   <= '0;
      elapsed_r    <= '0;
      fade_len_r   <= '0;
      hold_left_r  <= '0;
      out_ovr_r    <= '0;
      fi_armed_r   <= 1'b0;
      all_armed_r  <= 1'b0;
      front_r      <= 1'b0;
      in_pulse_r   <= 1'b0;
      all_pulse_r  <= 1'b0;
      t_r          <= '0;
      s_r          <= '0;
      prod_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      item_r       <= item_nxt;
      out_data_r   <= out_data_nxt;
      out_valid_r  <= out_valid_nxt;
      dfi_r        <= dfi_nxt;
      dfo_r        <= dfo_nxt;
      phase_r      <= phase_nxt;
      alpha_now_r  <= alpha_now_nxt;
      alpha_from_r <= alpha_from_nxt;
      alpha_to_r   <= alpha_to_nxt;
      elapsed_r    <= elapsed_nxt;
      fade_len_r   <= fade_len_nxt;
      hold_left_r  <= hold_left_nxt;
      out_ovr_r    <= out_ovr_nxt;
      fi_armed_r   <= fi_armed_nxt;
      all_armed_r  <= all_armed_nxt;
      front_r      <= front_nxt;
      in_pulse_r   <= in_pulse_nxt;
      all_pulse_r  <= all_pulse_nxt;
      t_r          <= t_nxt;
      s_r          <= s_nxt;
      prod_r       <= prod_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
  a_hold_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == sfs_pkg::PH_HOLD) |-> (hold_left_r != '0))
    else $error("holding with no hold time left");

  a_elapsed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    elapsed_r <= fade_len_r)
    else $error("elapsed time beyond fade length");

  a_alpha_bound: assert property (@(posedge clk) disable iff (!rst_n)
    alpha_now_r <= ALPHA_ONE)
    else $error("alpha above fully opaque");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside divide state");
`endif

endmodule

>>> rtl/sfs_div.sv
// Radix-2 restoring divider producing a fixed-point ratio one bit per cycle.
module sfs_div #(
  parameter int unsigned NUM_BITS = 24,
  parameter int unsigned Q_BITS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [NUM_BITS-1:0] den,
  output logic                done,
  output logic [Q_BITS-1:0]   quo
);

  localparam int unsigned CW = $clog2(Q_BITS);
  localparam logic [CW-1:0] LAST_CNT = CW'(Q_BITS - 1);

  logic                busy_r;
  logic                done_r;
  logic [CW-1:0]       cnt_r;
  logic [NUM_BITS:0]   rem_r;
  logic [NUM_BITS-1:0] den_r;
  logic [Q_BITS-1:0]   quo_r;

  logic                ge;
  logic [NUM_BITS:0]   rem_sub;
  logic [NUM_BITS:0]   rem_nxt;

  always_comb begin
    ge      = rem_r >= {1'b0, den_r};
    rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;
    rem_nxt = {rem_sub[NUM_BITS-1:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      den_r  <= '0;
      quo_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= {1'b0, num};
        den_r  <= den;
        cnt_r  <= LAST_CNT;
        quo_r  <= '0;
      end else if (busy_r) begin
        quo_r <= {quo_r[Q_BITS-2:0], ge};
        rem_r <= rem_nxt;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CW'(1);
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
